FILE: hdl/assert_macros.svh
// Assertion macros shared by the resampler RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define OSR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("osr assertion failed");

// Next-cycle implication, disabled while reset is high
`define OSR_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("osr assertion failed");

`endif

FILE: hdl/osr_pkg.sv
// Package for the odometer step resampler: widths, register codes, sequencer
// states, control structs and small arithmetic helpers. No dependencies.
package osr_pkg;

   localparam int unsigned MAX_BLOCK_LEN = 4096;
   localparam int unsigned MAX_REPEAT    = 64;

   localparam int unsigned ODO_W     = 32;
   localparam int unsigned WORD_W    = 64;
   localparam int unsigned STEP_W    = 16;
   localparam int unsigned LEN_W     = 13;
   localparam int unsigned SLOT_W    = 12;
   localparam int unsigned ACC_W     = 32;
   localparam int unsigned COPY_W    = $clog2(MAX_REPEAT + 1);
   localparam int unsigned CSR_AW    = 4;
   localparam int unsigned CSR_DW    = 32;
   localparam int unsigned DIV_STEPS = ODO_W;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [STEP_W-1:0] STEP_RESET  = STEP_W'(1);
   localparam logic [LEN_W-1:0]  LEN_RESET   = LEN_W'(4096);
   localparam logic [ODO_W-1:0]  START_RESET = '0;

   typedef enum logic [1:0] {
      REG_STEP         = 2'd0,
      REG_BLOCK_LEN    = 2'd1,
      REG_RECORD_COUNT = 2'd2,
      REG_START_ODO    = 2'd3
   } osr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_DECIDE,
      ST_ACC_ADD,
      ST_ACC_ADJ,
      ST_DIV,
      ST_EMIT
   } osr_state_type;

   typedef struct packed {
      logic [STEP_W-1:0] step_length;
      logic [LEN_W-1:0]  block_length;
      logic [LEN_W-1:0]  record_count;
      logic              start_wr;
      logic [ODO_W-1:0]  start_value;
   } osr_cfg_type;

   typedef struct packed {
      logic              start;
      logic [ODO_W-1:0]  dividend;
      logic [STEP_W-1:0] divisor;
   } osr_div_req_type;

   typedef struct packed {
      logic              done;
      logic [ODO_W-1:0]  quotient;
      logic [STEP_W-1:0] remainder;
   } osr_div_rsp_type;

   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
      logic [ACC_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
   endfunction

   function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] blen);
      logic [LEN_W-1:0] len;
      len = blen;
      if (len == '0) begin
         len = LEN_W'(1);
      end
      if (len > LEN_W'(MAX_BLOCK_LEN)) begin
         len = LEN_W'(MAX_BLOCK_LEN);
      end
      return len;
   endfunction

endpackage

FILE: hdl/odometer_step_resampler.sv
// Odometer step resampler: maps records onto slots spaced one step apart.
// Input channel req_*: one record (odometer reading, 64-bit word) per
// transaction. Output channel rsp_*: zero or more transactions per record,
// each a slot index, the record word and a flag on the final copy.
// Configuration through the csr_* APB-style port, written while idle;
// writing start_odometer starts a new block.
// Flow: after a record is accepted, its distance from the previous
// reading is formed; in pass-through mode it goes straight to the
// output, else a distance of one step goes to the output, a shorter one
// passes the accumulator add and adjust and may be dropped, and a longer
// one passes the bit-serial divider. Copies then leave one per cycle
// while the output is not stalled. req_stall stays high from acceptance
// until the final copy is in the output register or the record is
// dropped; the next record may be accepted while that copy still waits.
// A stalled output holds its register and pauses the copy sequence.
// Reset clears the registers to their defaults, the accumulator and slot
// counter to zero, and the output to empty.
// Depends on osr_pkg, osr_csr, osr_div and assert_macros.svh.
`include "assert_macros.svh"

module odometer_step_resampler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [osr_pkg::ODO_W-1:0]  req_odometer,
   input  logic [osr_pkg::WORD_W-1:0] req_record_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [osr_pkg::SLOT_W-1:0] rsp_slot,
   output logic [osr_pkg::WORD_W-1:0] rsp_payload,
   output logic                       rsp_last_copy,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [osr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [osr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [osr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready
);

   osr_pkg::osr_cfg_type     cfg;
   osr_pkg::osr_div_req_type div_req;
   osr_pkg::osr_div_rsp_type div_rsp;
   osr_pkg::osr_state_type   state_ff, state_in;

   logic [osr_pkg::ODO_W-1:0]  odo_ff, odo_in;
   logic [osr_pkg::WORD_W-1:0] word_ff, word_in;
   logic [osr_pkg::ODO_W-1:0]  dist_ff, dist_in;
   logic [osr_pkg::ODO_W-1:0]  prev_ff, prev_in;
   logic [osr_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic [osr_pkg::LEN_W-1:0]  nslot_ff, nslot_in;
   logic [osr_pkg::COPY_W-1:0] copies_ff, copies_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [osr_pkg::SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [osr_pkg::WORD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [osr_pkg::STEP_W-1:0] step_eff;
   logic [osr_pkg::LEN_W-1:0]  len_eff;
   logic [osr_pkg::LEN_W-1:0]  slot_cur;
   logic [osr_pkg::ODO_W-1:0]  step_wide;
   logic                       pass_mode;
   logic                       accept;
   logic                       out_free;
   logic                       emit;
   logic                       dist_eq, dist_lt;
   logic                       acc_ge;
   logic [osr_pkg::ACC_W:0]    acc_diff;
   logic                       quo_big;

   osr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   osr_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign step_eff  = (cfg.step_length == '0) ? osr_pkg::STEP_W'(1) : cfg.step_length;
   assign step_wide = osr_pkg::ODO_W'(step_eff);
   assign len_eff   = osr_pkg::eff_len(cfg.block_length);
   assign slot_cur  = (nslot_ff >= len_eff) ? (len_eff - 1'b1) : nslot_ff;
   assign pass_mode = (cfg.record_count == cfg.block_length);

   assign req_stall = (state_ff != osr_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign dist_eq  = (dist_ff == step_wide);
   assign dist_lt  = (dist_ff < step_wide);
   assign acc_diff = {1'b0, acc_ff} - {1'b0, osr_pkg::ACC_W'(step_eff)};
   assign acc_ge   = !acc_diff[osr_pkg::ACC_W];
   assign quo_big  = (div_rsp.quotient > osr_pkg::ODO_W'(osr_pkg::MAX_REPEAT));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         osr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = osr_pkg::ST_DIFF;
            end
         end
         osr_pkg::ST_DIFF: begin
            state_in = pass_mode ? osr_pkg::ST_EMIT : osr_pkg::ST_DECIDE;
         end
         osr_pkg::ST_DECIDE: begin
            if (dist_eq) begin
               state_in = osr_pkg::ST_EMIT;
            end else if (dist_lt) begin
               state_in = osr_pkg::ST_ACC_ADD;
            end else begin
               state_in = osr_pkg::ST_DIV;
            end
         end
         osr_pkg::ST_ACC_ADD: state_in = osr_pkg::ST_ACC_ADJ;
         osr_pkg::ST_ACC_ADJ: begin
            state_in = acc_ge ? osr_pkg::ST_IDLE : osr_pkg::ST_EMIT;
         end
         osr_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               state_in = osr_pkg::ST_EMIT;
            end
         end
         osr_pkg::ST_EMIT: begin
            if (out_free && copies_ff == osr_pkg::COPY_W'(1)) begin
               state_in = osr_pkg::ST_IDLE;
            end
         end
         default: state_in = osr_pkg::ST_IDLE;
      endcase
   end

   // control outputs of the sequencer
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = dist_ff;
      div_req.divisor  = step_eff;
      emit             = 1'b0;
      case (state_ff)
         osr_pkg::ST_DECIDE: div_req.start = !dist_eq && !dist_lt;
         osr_pkg::ST_EMIT:   emit          = out_free;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      odo_in         = odo_ff;
      word_in        = word_ff;
      dist_in        = dist_ff;
      prev_in        = prev_ff;
      acc_in         = acc_ff;
      nslot_in       = nslot_ff;
      copies_in      = copies_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_slot_in    = rsp_slot_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_last_in    = rsp_last_ff;

      if (cfg.start_wr) begin
         prev_in  = cfg.start_value;
         acc_in   = '0;
         nslot_in = '0;
      end

      case (state_ff)
         osr_pkg::ST_IDLE: begin
            if (accept) begin
               odo_in  = req_odometer;
               word_in = req_record_word;
            end
         end
         osr_pkg::ST_DIFF: begin
            // a zero or backward move counts as one step
            dist_in   = (odo_ff > prev_ff) ? (odo_ff - prev_ff) : step_wide;
            prev_in   = odo_ff;
            copies_in = osr_pkg::COPY_W'(1);
         end
         osr_pkg::ST_DECIDE: begin
            if (dist_eq) begin
               acc_in    = '0;
               copies_in = osr_pkg::COPY_W'(1);
            end else if (dist_lt) begin
               // hold the shortfall for the accumulator add
               dist_in = osr_pkg::ODO_W'(step_eff - dist_ff[osr_pkg::STEP_W-1:0]);
            end
         end
         osr_pkg::ST_ACC_ADD: begin
            acc_in = osr_pkg::sat_add(acc_ff, dist_ff);
         end
         osr_pkg::ST_ACC_ADJ: begin
            if (acc_ge) begin
               acc_in = acc_diff[osr_pkg::ACC_W-1:0];
            end
            copies_in = osr_pkg::COPY_W'(1);
         end
         osr_pkg::ST_DIV: begin
            if (div_rsp.done) begin
               copies_in = quo_big ? osr_pkg::COPY_W'(osr_pkg::MAX_REPEAT)
                                   : div_rsp.quotient[osr_pkg::COPY_W-1:0];
               acc_in    = osr_pkg::sat_add(acc_ff, osr_pkg::ACC_W'(div_rsp.remainder));
            end
         end
         default: ;
      endcase

      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_slot_in    = slot_cur[osr_pkg::SLOT_W-1:0];
         rsp_payload_in = word_ff;
         rsp_last_in    = (copies_ff == osr_pkg::COPY_W'(1));
         nslot_in       = slot_cur + 1'b1;
         copies_in      = copies_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= osr_pkg::ST_IDLE;
         prev_ff      <= osr_pkg::START_RESET;
         acc_ff       <= '0;
         nslot_ff     <= '0;
         copies_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         acc_ff       <= acc_in;
         nslot_ff     <= nslot_in;
         copies_ff    <= copies_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      odo_ff         <= odo_in;
      word_ff        <= word_in;
      dist_ff        <= dist_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_payload   = rsp_payload_ff;
   assign rsp_last_copy = rsp_last_ff;

   `OSR_ASSERT_IMP(a_div_done_in_div, clock, reset, div_rsp.done, state_ff == osr_pkg::ST_DIV)
   `OSR_ASSERT_IMP(a_emit_has_copies, clock, reset, state_ff == osr_pkg::ST_EMIT, copies_ff != '0)
   `OSR_ASSERT_IMP(a_slot_bounded, clock, reset, 1'b1, nslot_ff <= osr_pkg::LEN_W'(osr_pkg::MAX_BLOCK_LEN))
   `OSR_ASSERT_NXT(a_diff_branches, clock, reset, state_ff == osr_pkg::ST_DIFF, state_ff == osr_pkg::ST_DECIDE || state_ff == osr_pkg::ST_EMIT)

endmodule

FILE: hdl/osr_csr.sv
// Configuration registers of the odometer step resampler, APB-style port.
// Depends on osr_pkg.
module osr_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [osr_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [osr_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [osr_pkg::CSR_DW-1:0] csr_prdata,
   output logic                       csr_pready,
   output osr_pkg::osr_cfg_type       cfg
);

   logic [osr_pkg::STEP_W-1:0] step_ff, step_in;
   logic [osr_pkg::LEN_W-1:0]  blen_ff, blen_in;
   logic [osr_pkg::LEN_W-1:0]  rcount_ff, rcount_in;
   logic [osr_pkg::ODO_W-1:0]  start_ff, start_in;
   logic                       wr_en;
   osr_pkg::osr_reg_type       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = osr_pkg::osr_reg_type'(csr_paddr[3:2]);

   always_comb begin
      step_in   = step_ff;
      blen_in   = blen_ff;
      rcount_in = rcount_ff;
      start_in  = start_ff;
      if (wr_en) begin
         case (reg_sel)
            osr_pkg::REG_STEP:         step_in   = csr_pwdata[osr_pkg::STEP_W-1:0];
            osr_pkg::REG_BLOCK_LEN:    blen_in   = csr_pwdata[osr_pkg::LEN_W-1:0];
            osr_pkg::REG_RECORD_COUNT: rcount_in = csr_pwdata[osr_pkg::LEN_W-1:0];
            osr_pkg::REG_START_ODO:    start_in  = csr_pwdata[osr_pkg::ODO_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         osr_pkg::REG_STEP:         csr_prdata = osr_pkg::CSR_DW'(step_ff);
         osr_pkg::REG_BLOCK_LEN:    csr_prdata = osr_pkg::CSR_DW'(blen_ff);
         osr_pkg::REG_RECORD_COUNT: csr_prdata = osr_pkg::CSR_DW'(rcount_ff);
         osr_pkg::REG_START_ODO:    csr_prdata = osr_pkg::CSR_DW'(start_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff   <= osr_pkg::STEP_RESET;
         blen_ff   <= osr_pkg::LEN_RESET;
         rcount_ff <= osr_pkg::LEN_RESET;
         start_ff  <= osr_pkg::START_RESET;
      end else begin
         step_ff   <= step_in;
         blen_ff   <= blen_in;
         rcount_ff <= rcount_in;
         start_ff  <= start_in;
      end
   end

   // a start write also reloads the bookkeeping in the sequencer at the same edge
   assign cfg.step_length  = step_ff;
   assign cfg.block_length = blen_ff;
   assign cfg.record_count = rcount_ff;
   assign cfg.start_wr     = wr_en && (reg_sel == osr_pkg::REG_START_ODO);
   assign cfg.start_value  = csr_pwdata[osr_pkg::ODO_W-1:0];

endmodule

FILE: hdl/osr_div.sv
// Restoring divider: 32-bit dividend by 16-bit divisor, one quotient
// bit per cycle. Depends on osr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module osr_div (
   input  logic                     clock,
   input  logic                     reset,
   input  osr_pkg::osr_div_req_type req,
   output osr_pkg::osr_div_rsp_type rsp
);

   logic [osr_pkg::STEP_W-1:0]    rem_ff, rem_in;
   logic [osr_pkg::ODO_W-1:0]     quo_ff, quo_in;
   logic [osr_pkg::STEP_W-1:0]    dvs_ff, dvs_in;
   logic [osr_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [osr_pkg::STEP_W:0]      shifted;
   logic [osr_pkg::STEP_W:0]      trial;
   logic                          fits;

   assign shifted = {rem_ff, quo_ff[osr_pkg::ODO_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start && !busy_ff) begin
         rem_in  = '0;
         quo_in  = req.dividend;
         dvs_in  = req.divisor;
         cnt_in  = osr_pkg::DIV_CNT_W'(osr_pkg::DIV_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when the divisor fits
         rem_in = fits ? trial[osr_pkg::STEP_W-1:0] : shifted[osr_pkg::STEP_W-1:0];
         quo_in = {quo_ff[osr_pkg::ODO_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

   `OSR_ASSERT_IMP(a_rem_below_divisor, clock, reset, done_ff, rem_ff < dvs_ff)

endmodule

FILE: sim/tb_odometer_step_resampler.sv
// Self-checking testbench for odometer_step_resampler: a directed table, then random
// phases under several register settings, with every slot copy checked against a predictor.
// Depends on osr_pkg and the resampler RTL only.
module tb_odometer_step_resampler;

   localparam int unsigned CYCLE_LIMIT   = 2_000_000;
   localparam int unsigned SETTLE_CYCLES = 80;
   localparam int unsigned RAND_PHASES   = 8;
   localparam int unsigned PHASE_RECORDS = 63;
   localparam int unsigned HOLD_CYCLES   = 400;

   typedef struct packed {
      logic [osr_pkg::SLOT_W-1:0] slot;
      logic [osr_pkg::WORD_W-1:0] payload;
      logic                       last_copy;
   } slot_copy_type;

   typedef enum logic {
      ROW_CFG,
      ROW_REC
   } row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      osr_pkg::osr_reg_type       regsel;
      logic [31:0]                value;
      logic [osr_pkg::ODO_W-1:0]  odo;
      logic [osr_pkg::WORD_W-1:0] word;
      int                         exp_copies;
      int                         exp_slot;
   } stim_row_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [osr_pkg::ODO_W-1:0]    req_odometer = '0;
   logic [osr_pkg::WORD_W-1:0]   req_record_word = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [osr_pkg::SLOT_W-1:0]   rsp_slot;
   logic [osr_pkg::WORD_W-1:0]   rsp_payload;
   logic                         rsp_last_copy;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [osr_pkg::CSR_AW-1:0]   csr_paddr = '0;
   logic [osr_pkg::CSR_DW-1:0]   csr_pwdata = '0;
   logic [osr_pkg::CSR_DW-1:0]   csr_prdata;
   logic                         csr_pready;

   // predictor copy of the registers and the block state
   logic [osr_pkg::STEP_W-1:0]   model_step = osr_pkg::STEP_RESET;
   logic [osr_pkg::LEN_W-1:0]    model_blen = osr_pkg::LEN_RESET;
   logic [osr_pkg::LEN_W-1:0]    model_rcount = osr_pkg::LEN_RESET;
   logic [osr_pkg::ODO_W-1:0]    model_prev = osr_pkg::START_RESET;
   logic [osr_pkg::ACC_W-1:0]    model_acc = '0;
   logic [osr_pkg::LEN_W-1:0]    model_next_slot = '0;

   slot_copy_type       pending_copies[$];
   stim_row_type        directed_rows[$];

   int                  typed_copies = -1;
   int                  typed_slot = -1;
   bit                  quiet = 1'b0;
   bit                  hold_request = 1'b0;
   int unsigned         errors = 0;
   int unsigned         records_sent = 0;
   int unsigned         records_dropped = 0;
   int unsigned         copies_checked = 0;
   int unsigned         csr_writes = 0;
   int unsigned         cycle_count = 0;

   odometer_step_resampler u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_odometer    (req_odometer),
      .req_record_word (req_record_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_slot        (rsp_slot),
      .rsp_payload     (rsp_payload),
      .rsp_last_copy   (rsp_last_copy),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic logic [31:0] reg_mask(input osr_pkg::osr_reg_type r);
      case (r)
         osr_pkg::REG_STEP: begin
            return 32'h0000_FFFF;
         end
         osr_pkg::REG_BLOCK_LEN, osr_pkg::REG_RECORD_COUNT: begin
            return 32'h0000_1FFF;
         end
         default: begin
            return 32'hFFFF_FFFF;
         end
      endcase
   endfunction

   function automatic logic [osr_pkg::ACC_W-1:0] acc_add(input logic [osr_pkg::ACC_W-1:0] a,
                                                         input logic [osr_pkg::ACC_W-1:0] b);
      logic [osr_pkg::ACC_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[osr_pkg::ACC_W] ? {osr_pkg::ACC_W{1'b1}} : sum[osr_pkg::ACC_W-1:0];
   endfunction

   // Work out the slot copies for one record and queue them.
   task automatic resample_record(input logic [osr_pkg::ODO_W-1:0] odo,
                                  input logic [osr_pkg::WORD_W-1:0] word,
                                  output int unsigned copies);
      logic [31:0]               step32;
      logic [31:0]               distance;
      logic [osr_pkg::LEN_W-1:0] len;
      logic [osr_pkg::LEN_W-1:0] s;
      longint                    delta;
      step32 = (model_step == '0) ? 32'd1 : 32'(model_step);
      len = model_blen;
      if (len == '0) begin
         len = osr_pkg::LEN_W'(1);
      end
      if (len > osr_pkg::LEN_W'(osr_pkg::MAX_BLOCK_LEN)) begin
         len = osr_pkg::LEN_W'(osr_pkg::MAX_BLOCK_LEN);
      end
      copies = 1;
      if (model_rcount != model_blen) begin
         delta = longint'({32'd0, odo}) - longint'({32'd0, model_prev});
         if (delta <= 0) begin
            delta = longint'(step32);
         end
         distance = delta[31:0];
         if (distance == step32) begin
            model_acc = '0;
         end else if (distance < step32) begin
            model_acc = acc_add(model_acc, step32 - distance);
            if (model_acc >= step32) begin
               model_acc = model_acc - step32;
               copies = 0;
            end
         end else begin
            copies = distance / step32;
            model_acc = acc_add(model_acc, distance % step32);
         end
         if (copies > osr_pkg::MAX_REPEAT) begin
            copies = osr_pkg::MAX_REPEAT;
         end
      end
      model_prev = odo;
      for (int unsigned k = 0; k < copies; k++) begin
         s = model_next_slot;
         if (s >= len) begin
            s = len - osr_pkg::LEN_W'(1);
         end
         pending_copies.push_back('{s[osr_pkg::SLOT_W-1:0], word, (k + 1 == copies)});
         model_next_slot = s + osr_pkg::LEN_W'(1);
      end
   endtask

   always @(posedge clock) begin
      int unsigned   n;
      slot_copy_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            resample_record(req_odometer, req_record_word, n);
            records_sent++;
            if (n == 0) begin
               records_dropped++;
            end
            if (typed_copies >= 0) begin
               if (n != typed_copies ||
                   (n > 0 && pending_copies[pending_copies.size() - n].slot != typed_slot)) begin
                  $display("%0t: table row: expected %0d copies from slot %0d, predicted %0d",
                           $time, typed_copies, typed_slot, n);
                  errors++;
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_copies.size() == 0) begin
               $display("%0t: unexpected copy: expected none, actual slot %0d payload %h",
                        $time, rsp_slot, rsp_payload);
               errors++;
            end else begin
               want = pending_copies.pop_front();
               copies_checked++;
               if (rsp_slot != want.slot) begin
                  $display("%0t: slot mismatch: expected %0d, actual %0d",
                           $time, want.slot, rsp_slot);
                  errors++;
               end
               if (rsp_payload != want.payload) begin
                  $display("%0t: payload mismatch: expected %h, actual %h",
                           $time, want.payload, rsp_payload);
                  errors++;
               end
               if (rsp_last_copy != want.last_copy) begin
                  $display("%0t: last_copy mismatch: expected %0b, actual %0b",
                           $time, want.last_copy, rsp_last_copy);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d copies outstanding",
                  $time, pending_copies.size());
         $display("odometer_step_resampler regression: fail");
         $finish;
      end
   end

   // Receiver: random stall bursts, one long hold on request, none when quiet.
   initial begin
      forever begin
         if (hold_request) begin
            repeat (HOLD_CYCLES) @(negedge clock) rsp_stall <= 1'b1;
            hold_request = 1'b0;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            @(negedge clock) rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(1, 13)) @(negedge clock) rsp_stall <= 1'b1;
         end
      end
   end

   task automatic send_record(input logic [osr_pkg::ODO_W-1:0] odo,
                              input logic [osr_pkg::WORD_W-1:0] word,
                              input int exp_copies, input int exp_slot);
      @(negedge clock);
      req_valid <= 1'b1;
      req_odometer <= odo;
      req_record_word <= word;
      typed_copies = exp_copies;
      typed_slot = exp_slot;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
   endtask

   task automatic sender_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 13)) @(negedge clock) req_valid <= 1'b0;
      end
   endtask

   // Drop valid, wait for every copy, then let a dropped record finish.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_copies.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input osr_pkg::osr_reg_type regsel, input logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] masked;
      masked = value & reg_mask(regsel);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= osr_pkg::CSR_AW'({regsel, 2'b00});
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      case (regsel)
         osr_pkg::REG_STEP: begin
            model_step = masked[osr_pkg::STEP_W-1:0];
         end
         osr_pkg::REG_BLOCK_LEN: begin
            model_blen = masked[osr_pkg::LEN_W-1:0];
         end
         osr_pkg::REG_RECORD_COUNT: begin
            model_rcount = masked[osr_pkg::LEN_W-1:0];
         end
         default: begin
            // a new block: reload the reading, clear accumulator and slot
            model_prev = masked;
            model_acc = '0;
            model_next_slot = '0;
         end
      endcase
      csr_writes++;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      readback = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback != masked) begin
         $display("%0t: readback of %s: expected %h, actual %h",
                  $time, regsel.name(), masked, readback);
         errors++;
      end
   endtask

   initial begin
      stim_row_type      row;
      logic [31:0]       step32;
      logic [31:0]       gen_odo;
      logic [31:0]       odo;
      logic [15:0]       new_step;
      logic [12:0]       new_blen;
      logic [12:0]       new_rcount;
      logic [31:0]       new_start;
      int unsigned       pick;

      // after reset: pass-through, then one step of 1
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd0, 64'd0, 1, 0});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'hFFFF_FFFF, '1, 1, 1});
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_RECORD_COUNT, 32'd100, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd0,
                                64'h0123_4567_89AB_CDEF, 1, 2});
      // step 10: exact, short, dropped, long, backwards-zero, saturated repeats
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_STEP, 32'd10, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_START_ODO, 32'd1000, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd1010,
                                64'hFEDC_BA98_7654_3210, 1, 0});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd1013,
                                64'h5555_5555_5555_5555, -1, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd1016,
                                64'hAAAA_AAAA_AAAA_AAAA, 0, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd1041,
                                64'h8000_0000_0000_0001, -1, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd1041,
                                64'h7FFF_FFFF_FFFF_FFFE, -1, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd2000,
                                64'h0F0F_0F0F_F0F0_F0F0, 64, 5});
      // slot clamp at a short block
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_BLOCK_LEN, 32'd3, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd2010,
                                64'h1234_5678_9ABC_DEF0, 1, 2});
      // zero step and zero block length
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_STEP, 32'd0, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_BLOCK_LEN, 32'd0, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_START_ODO, 32'd5, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd8,
                                64'hDEAD_BEEF_CAFE_F00D, 3, 0});
      // oversized length equal to the count: pass-through
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_BLOCK_LEN, 32'h1FFF, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_RECORD_COUNT, 32'h1FFF, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd3, 64'd1, 1, 1});
      // widest step
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_STEP, 32'hFFFF, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_RECORD_COUNT, 32'd1, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_BLOCK_LEN, 32'd4096, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_CFG, osr_pkg::REG_START_ODO, 32'd0, '0, '0, -1, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'hFFFF, 64'h2, 1, 0});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'hFFFF_FFFF, 64'h4,
                                64, 1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd1, 64'h8, -1, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd2, 64'h10, -1, -1});
      directed_rows.push_back('{ROW_REC, osr_pkg::REG_STEP, 32'd0, 32'd3, 64'h20, 0, -1});

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.kind == ROW_CFG) begin
            settle();
            csr_write(row.regsel, row.value);
         end else begin
            sender_gap();
            send_record(row.odo, row.word, row.exp_copies, row.exp_slot);
         end
      end

      for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
         settle();
         pick = $urandom_range(0, 9);
         new_step = (pick == 0) ? 16'd0 : (pick < 3) ? 16'd1 :
                    (pick < 7) ? 16'($urandom_range(2, 50)) : 16'($urandom);
         pick = $urandom_range(0, 9);
         new_blen = (pick == 0) ? 13'd0 : (pick == 1) ? 13'd1 :
                    (pick < 5) ? 13'($urandom_range(2, 16)) :
                    (pick < 8) ? 13'd4096 : 13'($urandom);
         new_rcount = ($urandom_range(0, 3) == 0) ? new_blen : 13'($urandom);
         new_start = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 5000);
         case (phase)
            0: new_step = 16'd1;
            1: new_step = 16'hFFFF;
            2: new_rcount = new_blen;
            default: ;
         endcase
         if (phase == RAND_PHASES - 1) begin
            quiet = 1'b1;
         end
         csr_write(osr_pkg::REG_STEP, 32'(new_step));
         csr_write(osr_pkg::REG_BLOCK_LEN, 32'(new_blen));
         csr_write(osr_pkg::REG_RECORD_COUNT, 32'(new_rcount));
         csr_write(osr_pkg::REG_START_ODO, new_start);
         gen_odo = new_start;
         step32 = (new_step == 0) ? 32'd1 : 32'(new_step);
         if (phase == 3) begin
            hold_request = 1'b1;
         end
         for (int unsigned n = 0; n < PHASE_RECORDS; n++) begin
            if (phase == 5 && n == PHASE_RECORDS / 2) begin
               // hold the sender until every copy has drained
               @(negedge clock);
               req_valid <= 1'b0;
               while (pending_copies.size() != 0) begin
                  @(posedge clock);
               end
            end
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
               odo = gen_odo + step32;
            end else if (pick < 45) begin
               odo = gen_odo + $urandom_range(0, step32 - 1);
            end else if (pick < 80) begin
               odo = gen_odo + step32 * $urandom_range(1, 6) + $urandom_range(0, step32 - 1);
            end else if (pick < 88) begin
               odo = gen_odo + step32 * $urandom_range(7, 80);
            end else if (pick < 94) begin
               odo = $urandom;
            end else begin
               odo = gen_odo - $urandom_range(1, 1000);
            end
            gen_odo = odo;
            sender_gap();
            send_record(odo, {$urandom, $urandom}, -1, -1);
         end
      end

      settle();
      if (pending_copies.size() != 0) begin
         $display("%0t: %0d copies expected but never seen", $time, pending_copies.size());
         errors++;
      end
      $display("Covered %0d records (%0d dropped) and %0d slot copies over %0d register writes,",
               records_sent, records_dropped, copies_checked, csr_writes);
      $display("with a %0d-cycle output hold, a full drain pause and an unthrottled last phase.",
               HOLD_CYCLES);
      if (errors == 0) begin
         $display("odometer_step_resampler regression: pass");
      end else begin
         $display("odometer_step_resampler regression: fail");
      end
      $finish;
   end

endmodule

FILE: odometer_step_resampler.f
+incdir+hdl
hdl/osr_pkg.sv
hdl/osr_csr.sv
hdl/osr_div.sv
hdl/odometer_step_resampler.sv
sim/tb_odometer_step_resampler.sv
